>>> design/desa_pkg.sv
// Package for the double-ended stack allocator.
// Holds command and status codes, field widths and default parameter values.
// No dependencies.
package desa_pkg;

  localparam int OFFSET_BITS_DEFAULT  = 21;
  localparam int HEADER_BYTES_DEFAULT = 1;

  localparam int MARK_W  = 21;
  localparam int ADDR_W  = 32;
  localparam int ALIGN_W = 8;
  localparam int CFG_W   = 32;

  localparam logic [MARK_W-1:0]  REGION_RESET = MARK_W'(1048576);
  localparam logic [ALIGN_W-1:0] ALIGN_MAX    = ALIGN_W'(128);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_GET   = 2'd2,
    CMD_CLEAR = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_ALIGN  = 2'd1,
    STATUS_NO_ROOM    = 2'd2,
    STATUS_BAD_MARKER = 2'd3
  } status_t;

  typedef enum logic {
    REG_BASE_ADDRESS = 1'b0,
    REG_REGION_SIZE  = 1'b1
  } cfg_reg_t;

endpackage

>>> design/double_ended_stack_allocator_top.sv
// Double-ended stack allocator, top level.
// Bottom and top markers over one region, command decode and result register.
// Depends on desa_pkg.
//
// One command is accepted per cycle. Its result appears in the output register
// on the next cycle; a new command is taken whenever that register is empty or
// being emptied in the same cycle, so sustained throughput is one transaction
// per clock while out_ready stays high. The marker update and the aligned address
// are worked out in one pass from the accepted command and the current markers.
module double_ended_stack_allocator_top
  import desa_pkg::*;
#(
  parameter int OFFSET_BITS  = OFFSET_BITS_DEFAULT,
  parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic               end_select,
  input  logic [MARK_W-1:0]  request_bytes,
  input  logic [ALIGN_W-1:0] align_bytes,
  input  logic [MARK_W-1:0]  marker_in,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [ADDR_W-1:0]  address,
  output logic [MARK_W-1:0]  marker_out
);

  localparam int OB  = OFFSET_BITS;
  localparam int MW  = (OB > MARK_W) ? OB : MARK_W;
  localparam int EW  = MARK_W + 1;
  localparam int CW  = ((OB > EW) ? OB : EW) + 1;
  localparam logic [MW-1:0] REGION_RESET_W = MW'(REGION_RESET);

  logic [ADDR_W-1:0] base_address;
  logic [MARK_W-1:0] region_size;
  logic [OB-1:0]     bottom_marker, bottom_marker_next;
  logic [OB-1:0]     top_marker, top_marker_next;

  logic [MW-1:0]     region_wide;
  logic [OB-1:0]     region_off;
  logic              accept;
  command_t          cmd;
  status_t           status_next;
  logic [ADDR_W-1:0] address_next;
  logic [MW-1:0]     marker_wide;
  logic              align_ok;
  logic [EW-1:0]     expanded;
  logic [CW-1:0]     bottom_sum;
  logic [CW-1:0]     top_gap;
  logic [OB-1:0]     top_alloc;
  logic [OB-1:0]     block_offset;
  logic [ADDR_W-1:0] align_mask;
  logic [ADDR_W-1:0] raw_address;

  assign region_wide = MW'(region_size);
  assign region_off  = region_wide[OB-1:0];
  assign in_ready    = !out_valid || out_ready;
  assign accept      = in_valid && in_ready;
  assign cmd         = command_t'(command);

  assign align_ok   = (align_bytes != '0) && (align_bytes <= ALIGN_MAX) &&
                      ((align_bytes & (align_bytes - ALIGN_W'(1))) == '0);
  assign expanded   = EW'(request_bytes) + EW'(align_bytes);
  assign bottom_sum = CW'(bottom_marker) + CW'(expanded);
  assign top_gap    = CW'(top_marker) - CW'(bottom_marker);
  assign top_alloc  = OB'(CW'(top_marker) - CW'(expanded));
  assign block_offset = end_select ? top_alloc : bottom_marker;
  assign align_mask   = ~(ADDR_W'(align_bytes) - ADDR_W'(1));
  assign raw_address  = base_address + ADDR_W'(block_offset) + ADDR_W'(HEADER_BYTES) +
                        ADDR_W'(align_bytes) - ADDR_W'(1);

  always_comb begin
    status_next        = STATUS_OK;
    address_next       = '0;
    bottom_marker_next = bottom_marker;
    top_marker_next    = top_marker;
    case (cmd)
      CMD_ALLOC: begin
        if (!align_ok) begin
          status_next = STATUS_BAD_ALIGN;
        end else if (!end_select) begin
          if (bottom_sum > CW'(top_marker)) begin
            status_next = STATUS_NO_ROOM;
          end else begin
            address_next       = raw_address & align_mask;
            bottom_marker_next = bottom_sum[OB-1:0];
          end
        end else begin
          if ((top_marker < bottom_marker) || (CW'(expanded) > top_gap)) begin
            status_next = STATUS_NO_ROOM;
          end else begin
            top_marker_next = top_alloc;
            address_next    = raw_address & align_mask;
          end
        end
      end
      CMD_FREE: begin
        if (!end_select) begin
          if (MW'(marker_in) > MW'(bottom_marker)) begin
            status_next = STATUS_BAD_MARKER;
          end else begin
            bottom_marker_next = OB'(MW'(marker_in));
          end
        end else begin
          if ((MW'(marker_in) < MW'(top_marker)) || (MW'(marker_in) > MW'(region_off))) begin
            status_next = STATUS_BAD_MARKER;
          end else begin
            top_marker_next = OB'(MW'(marker_in));
          end
        end
      end
      CMD_CLEAR: begin
        bottom_marker_next = '0;
        top_marker_next    = region_off;
      end
      default: ;
    endcase
    marker_wide = end_select ? MW'(top_marker_next) : MW'(bottom_marker_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      region_size  <= REGION_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_REGION_SIZE:  region_size  <= cfg_data[MARK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bottom_marker <= '0;
      top_marker    <= REGION_RESET_W[OB-1:0];
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        bottom_marker <= bottom_marker_next;
        top_marker    <= top_marker_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      address    <= address_next;
      marker_out <= marker_wide[MARK_W-1:0];
    end
  end

endmodule

>>> design/desa_checker.sv
// Port-level checks for the double-ended stack allocator, with its bind.
// Depends on desa_pkg and double_ended_stack_allocator_top.
module desa_checker
  import desa_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [ADDR_W-1:0]  address,
  input logic [MARK_W-1:0]  marker_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(address) &&
    $stable(marker_out))
    else $error("result changed while stalled");

  a_fail_no_address: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> address == '0)
    else $error("failed transaction carries an address");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction gave no result");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind double_ended_stack_allocator_top desa_checker u_desa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .address    (address),
  .marker_out (marker_out)
);
